// ===== hw/rtl/escaped_command_frame_builder_assert.svh =====
// Assertion macros for the escaped command frame builder.
// Included by the modules that assert; needs nothing else.
`ifndef ESCAPED_COMMAND_FRAME_BUILDER_ASSERT_SVH
`define ESCAPED_COMMAND_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication
`define ECFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ecfb_pkg.sv =====
// Shared types and constants of the escaped command frame builder.
// No dependencies.
package ecfb_pkg;

  localparam int LANE_CNT  = 5;   // code byte plus four value bytes
  localparam int FRAME_MAX = 12;  // start + 5 stuffed pairs + stop
  localparam int CNT_W     = 4;   // holds 1..FRAME_MAX

  localparam logic [2:0] REG_START_SYM = 3'd0;
  localparam logic [2:0] REG_STOP_SYM  = 3'd1;
  localparam logic [2:0] REG_ESC_SYM   = 3'd2;
  localparam logic [2:0] REG_ESC_MASK  = 3'd3;
  localparam logic [2:0] REG_SET_FREQ  = 3'd4;

  localparam logic [7:0] RST_START_SYM = 8'd126;
  localparam logic [7:0] RST_STOP_SYM  = 8'd125;
  localparam logic [7:0] RST_ESC_SYM   = 8'd124;
  localparam logic [7:0] RST_ESC_MASK  = 8'd32;
  localparam logic [7:0] RST_SET_FREQ  = 8'd1;

  typedef struct packed {
    logic [7:0] start_sym;
    logic [7:0] stop_sym;
    logic [7:0] esc_sym;
    logic [7:0] esc_mask;
  } sym_t;

  typedef struct packed {
    logic       esc;
    logic [7:0] data;
  } lane_out_t;

  typedef logic [FRAME_MAX-1:0][7:0] frame_t;

endpackage

// ===== hw/rtl/escaped_command_frame_builder.sv =====
// An accepted item is registered in the lane stage, then loaded into the serializer; one result per cycle.
// Throughput: one item per frame of 7 to 12 bytes (1 for a rejected code), set by the
// single-byte output serializer; a lane stage holds the next item meanwhile.
// Reset (rst_n low, synchronous): symbol registers to defaults, lane stage and
// serializer empty. The receiver cannot stall; results are strobed by out_valid.
module escaped_command_frame_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_command_code,
  input  logic [31:0] in_command_value,
  output logic        out_valid,
  output logic [7:0]  out_byte,
  output logic        out_end_of_frame,
  output logic        out_rejected,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ecfb_pkg::*;
  `include "escaped_command_frame_builder_assert.svh"

  sym_t       sym_r;
  logic [7:0] set_freq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r.start_sym <= RST_START_SYM;
      sym_r.stop_sym  <= RST_STOP_SYM;
      sym_r.esc_sym   <= RST_ESC_SYM;
      sym_r.esc_mask  <= RST_ESC_MASK;
      set_freq_r      <= RST_SET_FREQ;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_SYM: sym_r.start_sym <= cfg_data;
        REG_STOP_SYM:  sym_r.stop_sym  <= cfg_data;
        REG_ESC_SYM:   sym_r.esc_sym   <= cfg_data;
        REG_ESC_MASK:  sym_r.esc_mask  <= cfg_data;
        REG_SET_FREQ:  set_freq_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // lanes, most significant byte first after the code
  logic [LANE_CNT-1:0][7:0] lane_in;
  lane_out_t [LANE_CNT-1:0] lane_res;

  assign lane_in[0] = in_command_code;
  assign lane_in[1] = in_command_value[31:24];
  assign lane_in[2] = in_command_value[23:16];
  assign lane_in[3] = in_command_value[15:8];
  assign lane_in[4] = in_command_value[7:0];

  for (genvar g = 0; g < LANE_CNT; g++) begin : g_lane
    ecfb_lane u_lane (
      .data_in  (lane_in[g]),
      .sym      (sym_r),
      .lane_out (lane_res[g])
    );
  end

  // lane stage
  logic                     st_valid_r, st_valid_nxt;
  lane_out_t [LANE_CNT-1:0] st_lanes_r;
  logic                     st_rej_r;

  // serializer
  logic             ser_active_r, ser_active_nxt;
  logic [CNT_W-1:0] ser_cnt_r, ser_cnt_nxt;
  frame_t           ser_frame_r, ser_frame_nxt;
  logic             ser_rej_r, ser_rej_nxt;

  frame_t           mrg_frame;
  logic [CNT_W-1:0] mrg_len;
  logic             ser_last, ser_free, load, accept;

  ecfb_merge u_merge (
    .lanes (st_lanes_r),
    .sym   (sym_r),
    .rej   (st_rej_r),
    .frame (mrg_frame),
    .len   (mrg_len)
  );

  assign ser_last = ser_active_r && (ser_cnt_r == CNT_W'(1));
  assign ser_free = !ser_active_r || ser_last;
  assign load     = st_valid_r && ser_free;
  assign busy     = st_valid_r && !load;
  assign accept   = start && !busy;

  always_comb begin
    st_valid_nxt   = st_valid_r;
    ser_active_nxt = ser_active_r;
    ser_cnt_nxt    = ser_cnt_r;
    ser_frame_nxt  = ser_frame_r;
    ser_rej_nxt    = ser_rej_r;
    if (load) begin
      st_valid_nxt = 1'b0;
    end
    if (accept) begin
      st_valid_nxt = 1'b1;
    end
    if (ser_active_r) begin
      ser_cnt_nxt   = ser_cnt_r - CNT_W'(1);
      ser_frame_nxt = {8'h00, ser_frame_r[FRAME_MAX-1:1]};
      if (ser_last) begin
        ser_active_nxt = 1'b0;
      end
    end
    if (load) begin
      ser_active_nxt = 1'b1;
      ser_cnt_nxt    = mrg_len;
      ser_frame_nxt  = mrg_frame;
      ser_rej_nxt    = st_rej_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r   <= 1'b0;
      ser_active_r <= 1'b0;
      ser_cnt_r    <= '0;
    end else begin
      st_valid_r   <= st_valid_nxt;
      ser_active_r <= ser_active_nxt;
      ser_cnt_r    <= ser_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_lanes_r <= lane_res;
      st_rej_r   <= (in_command_code != set_freq_r);
    end
    ser_frame_r <= ser_frame_nxt;
    ser_rej_r   <= ser_rej_nxt;
  end

  assign out_valid        = ser_active_r;
  assign out_byte         = ser_frame_r[0];
  assign out_end_of_frame = ser_active_r && (ser_cnt_r == CNT_W'(1));
  assign out_rejected     = ser_active_r && ser_rej_r;

  `ECFB_ASSERT_IMPL(a_rej_ends, clk, rst_n, out_valid && out_rejected, out_end_of_frame, "rejection not single result")
  `ECFB_ASSERT_IMPL(a_busy_held, clk, rst_n, busy, st_valid_r && ser_active_r && !ser_last, "busy without held item")
  `ECFB_ASSERT_IMPL(a_cnt_range, clk, rst_n, ser_active_r, (ser_cnt_r != '0) && (ser_cnt_r <= CNT_W'(FRAME_MAX)), "serializer count out of range")
  `ECFB_ASSERT_NEXT(a_frame_cont, clk, rst_n, out_valid && !out_end_of_frame, out_valid && !out_rejected, "frame bytes not contiguous")

endmodule

// ===== hw/rtl/ecfb_lane.sv =====
// One payload lane: symbol compare and stuffing of a single byte.
// Depends on ecfb_pkg.
module ecfb_lane (
  input  logic [7:0]         data_in,
  input  ecfb_pkg::sym_t     sym,
  output ecfb_pkg::lane_out_t lane_out
);
  import ecfb_pkg::*;

  logic hit;

  assign hit = (data_in == sym.start_sym) || (data_in == sym.stop_sym) ||
               (data_in == sym.esc_sym);

  always_comb begin
    lane_out.esc  = hit;
    lane_out.data = hit ? (data_in | sym.esc_mask) : data_in;
  end

endmodule

// ===== hw/rtl/ecfb_merge.sv =====
// Merge stage: packs the lane results into a frame with start and stop symbols,
// or a single zero byte for a rejected code. Depends on ecfb_pkg.
module ecfb_merge (
  input  ecfb_pkg::lane_out_t [ecfb_pkg::LANE_CNT-1:0] lanes,
  input  ecfb_pkg::sym_t                               sym,
  input  logic                                         rej,
  output ecfb_pkg::frame_t                             frame,
  output logic [ecfb_pkg::CNT_W-1:0]                   len
);
  import ecfb_pkg::*;

  logic [CNT_W-1:0] pos;

  always_comb begin
    frame = '0;
    pos   = CNT_W'(1);
    if (rej) begin
      len = CNT_W'(1);
    end else begin
      frame[0] = sym.start_sym;
      for (int i = 0; i < LANE_CNT; i++) begin
        if (lanes[i].esc) begin
          frame[pos]         = sym.esc_sym;
          frame[pos + 1'b1]  = lanes[i].data;
          pos                = pos + CNT_W'(2);
        end else begin
          frame[pos] = lanes[i].data;
          pos        = pos + CNT_W'(1);
        end
      end
      frame[pos] = sym.stop_sym;
      len        = pos + CNT_W'(1);
    end
  end

endmodule
